FILE: src/utf8_surrogate_replacer_defines.svh
// ----------------------------------------------------------------------------
// utf8 surrogate replacer assertion macros
// concurrent checks that compile away when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef UTF8_SURROGATE_REPLACER_DEFINES_SVH
`define UTF8_SURROGATE_REPLACER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define USR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("usr check failed");

// next-cycle implication
`define USR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("usr check failed");

`else

`define USR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define USR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/usr_pkg.sv
// ----------------------------------------------------------------------------
// usr_pkg
// shared types and byte constants of the utf8 surrogate replacer
// ----------------------------------------------------------------------------
package usr_pkg;

	localparam logic [7:0] LEAD_BYTE = 8'hED;
	localparam logic [7:0] SECOND_LO = 8'hA0;
	localparam logic [7:0] CONT_LO   = 8'h80;
	localparam logic [7:0] CONT_HI   = 8'hBF;
	localparam logic [7:0] REPL_0    = 8'hEF;
	localparam logic [7:0] REPL_1    = 8'hBF;
	localparam logic [7:0] REPL_2    = 8'hBD;

	// what the front holds back
	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_LEAD,
		HOLD_PAIR
	} hold_t;

	// up to three bytes released by one input item
	typedef struct packed {
		logic [1:0]      cnt;
		logic            last;
		logic [2:0][7:0] bytes;
	} burst_t;

endpackage

FILE: src/usr_front.sv
// ----------------------------------------------------------------------------
// usr_front
// classifies each input item against the held prefix and builds a burst
// ----------------------------------------------------------------------------
`include "utf8_surrogate_replacer_defines.svh"

module usr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	output logic           burst_wr,
	output usr_pkg::burst_t burst
);

	usr_pkg::hold_t hold_q;
	usr_pkg::hold_t hold_nxt;
	logic [7:0]     second_q;
	logic [7:0]     second_nxt;
	logic [1:0]     pre;
	logic           fresh;
	logic           is_lead;
	logic           is_second;
	logic           is_cont;

	assign is_lead   = in_byte == usr_pkg::LEAD_BYTE;
	assign is_second = (in_byte >= usr_pkg::SECOND_LO) && (in_byte <= usr_pkg::CONT_HI);
	assign is_cont   = (in_byte >= usr_pkg::CONT_LO) && (in_byte <= usr_pkg::CONT_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= usr_pkg::HOLD_NONE;
		end else if (accept) begin
			hold_q <= hold_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			second_q <= second_nxt;
		end
	end

	always_comb begin
		hold_nxt   = hold_q;
		second_nxt = second_q;
		burst      = '0;
		pre        = 2'd0;
		fresh      = 1'b1;
		case (hold_q)
			usr_pkg::HOLD_LEAD: begin
				if (is_second && !in_last) begin
					hold_nxt   = usr_pkg::HOLD_PAIR;
					second_nxt = in_byte;
					fresh      = 1'b0;
				end else begin
					burst.bytes[0] = usr_pkg::LEAD_BYTE;
					pre            = 2'd1;
				end
			end
			usr_pkg::HOLD_PAIR: begin
				if (is_cont) begin
					burst.bytes[0] = usr_pkg::REPL_0;
					burst.bytes[1] = usr_pkg::REPL_1;
					burst.bytes[2] = usr_pkg::REPL_2;
					burst.cnt      = 2'd3;
					burst.last     = in_last;
					hold_nxt       = usr_pkg::HOLD_NONE;
					fresh          = 1'b0;
				end else begin
					burst.bytes[0] = usr_pkg::LEAD_BYTE;
					burst.bytes[1] = second_q;
					pre            = 2'd2;
				end
			end
			default: begin
			end
		endcase
		if (fresh) begin
			if (is_lead && !in_last) begin
				hold_nxt  = usr_pkg::HOLD_LEAD;
				burst.cnt = pre;
			end else begin
				hold_nxt   = usr_pkg::HOLD_NONE;
				burst.cnt  = pre + 2'd1;
				burst.last = in_last;
				case (pre)
					2'd0:    burst.bytes[0] = in_byte;
					2'd1:    burst.bytes[1] = in_byte;
					default: burst.bytes[2] = in_byte;
				endcase
			end
		end
	end

	assign burst_wr = accept && (burst.cnt != 2'd0);

	`USR_ASSERT_NXT(a_last_clears_hold, clk, arst_n, accept && in_last, hold_q == usr_pkg::HOLD_NONE)
	`USR_ASSERT_IMP(a_pair_second_ok, clk, arst_n, hold_q == usr_pkg::HOLD_PAIR, second_q >= usr_pkg::SECOND_LO)

endmodule

FILE: src/usr_queue.sv
// ----------------------------------------------------------------------------
// usr_queue
// short burst queue between the front and the back
// ----------------------------------------------------------------------------
`include "utf8_surrogate_replacer_defines.svh"

module usr_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  usr_pkg::burst_t wr_data,
	output logic            full,
	input  logic            rd,
	output usr_pkg::burst_t rd_data,
	output logic            nonempty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	usr_pkg::burst_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full     = cnt_q == CW'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign do_wr    = wr && !full;
	assign do_rd    = rd && nonempty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`USR_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))
	`USR_ASSERT_NXT(a_wr_only_grows, clk, arst_n, do_wr && !do_rd, cnt_q == $past(cnt_q) + 1'b1)

endmodule

FILE: src/usr_back.sv
// ----------------------------------------------------------------------------
// usr_back
// serializes queued bursts into single output bytes from a register
// ----------------------------------------------------------------------------
`include "utf8_surrogate_replacer_defines.svh"

module usr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nonempty,
	input  usr_pkg::burst_t q_data,
	output logic            q_rd,
	input  logic            pop,
	output logic            empty,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	usr_pkg::burst_t cur_q;
	logic            valid_q;
	logic [1:0]      idx_q;
	logic            done;
	logic            take;
	logic            load;

	assign done  = idx_q == (cur_q.cnt - 2'd1);
	assign take  = valid_q && pop;
	assign load  = q_nonempty && (!valid_q || (take && done));
	assign q_rd  = load;
	assign empty = !valid_q;

	always_comb begin
		case (idx_q)
			2'd0:    out_byte = cur_q.bytes[0];
			2'd1:    out_byte = cur_q.bytes[1];
			default: out_byte = cur_q.bytes[2];
		endcase
	end

	assign out_last = cur_q.last && done;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (take) begin
			if (done) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	`USR_ASSERT_IMP(a_cur_not_blank, clk, arst_n, valid_q, cur_q.cnt != 2'd0)
	`USR_ASSERT_NXT(a_stall_holds, clk, arst_n, valid_q && !pop, valid_q && (idx_q == $past(idx_q)))

endmodule

FILE: src/utf8_surrogate_replacer.sv
// ----------------------------------------------------------------------------
// utf8_surrogate_replacer
// replaces three-byte utf8 encoded surrogates with EF BF BD in a byte stream
// ----------------------------------------------------------------------------
// input side: drive in_byte/in_last with push; an item is taken at a clock
//   edge with push high and full low. in_last marks the final stream byte
// output side: while empty is low, out_byte/out_last show the oldest byte;
//   pop high with empty low takes it. out_last marks the final output byte
// a byte that may start a surrogate (ED, then A0..BF) is held back until
//   the sequence completes or breaks; a last item flushes all held bytes
// an item that releases bytes writes its burst into the queue at the accepting
//   edge; the back register then loads it and shows its first byte for popping;
//   held bytes wait for the item that resolves them
// throughput: one item per cycle in while full is low, one byte per cycle
//   out while pop is high; the back register drains up to three bytes per burst
// a burst queue of QUEUE_DEPTH entries sits between the classifier and the
//   output serializer; when the receiver stalls the queue fills and full
//   rises, stopping input until pops free an entry
// reset: arst_n clears held bytes, the queue and the output register
// ----------------------------------------------------------------------------
module utf8_surrogate_replacer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic            accept;
	logic            burst_wr;
	usr_pkg::burst_t burst;
	logic            q_rd;
	logic            q_nonempty;
	usr_pkg::burst_t q_data;

	assign accept = push && !full;

	usr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.burst_wr (burst_wr),
		.burst    (burst)
	);

	usr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (burst_wr),
		.wr_data  (burst),
		.full     (full),
		.rd       (q_rd),
		.rd_data  (q_data),
		.nonempty (q_nonempty)
	);

	usr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

endmodule
